[design/fbd_pkg.sv]
// Shared constants, codes and queue entry type of the frame buffer drawer.
`default_nettype none

package fbd_pkg;

  // Panel and glyph geometry
  localparam int PANEL_COLS = 240;
  localparam int PANEL_ROWS = 240;
  localparam int GLYPH_W = 8;
  localparam int GLYPH_H = 16;
  localparam int GLYPH_COUNT = 256;

  localparam int FRAME_DEPTH = PANEL_COLS * PANEL_ROWS;
  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_H;
  localparam int FRAME_AW = $clog2(FRAME_DEPTH);
  localparam int FONT_AW = $clog2(FONT_DEPTH);
  localparam int COL_W = $clog2(PANEL_COLS);
  localparam int ROW_W = $clog2(PANEL_ROWS);
  localparam int GCOL_W = $clog2(GLYPH_W);
  localparam int GROW_W = $clog2(GLYPH_H);

  // Field widths
  localparam int COLOR_W = 16;
  localparam int CODE_W = 8;
  localparam int POS_W = 12;
  localparam int SIZE_W = 11;

  // Signed working width for clipping: a 12-bit position plus an 11-bit size
  localparam int COORD_W = 14;
  localparam logic signed [COORD_W-1:0] COLS_S = COORD_W'(PANEL_COLS);
  localparam logic signed [COORD_W-1:0] ROWS_S = COORD_W'(PANEL_ROWS);
  localparam logic signed [COORD_W-1:0] GLYPH_W_S = COORD_W'(GLYPH_W);
  localparam logic signed [COORD_W-1:0] GLYPH_H_S = COORD_W'(GLYPH_H);
  localparam logic signed [COORD_W-1:0] ONE_S = COORD_W'(1);

  // Address step from one frame row to the next
  localparam logic [FRAME_AW-1:0] COL_STRIDE = FRAME_AW'(PANEL_COLS);

  // Command queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CLEAR_COLOR = 1'b0;

  // Input opcodes
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_RECT  = 3'd1,
    OP_CHAR  = 3'd2,
    OP_FONT  = 3'd3,
    OP_READ  = 3'd4
  } opcode_t;

  // Work classes handed to the back end
  typedef enum logic [1:0] {
    K_FILL  = 2'd0,
    K_GLYPH = 2'd1,
    K_FONT  = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  // One queued job: a clipped pixel window or a single access
  typedef struct packed {
    kind_t               kind;
    logic [COL_W-1:0]    col_first;
    logic [COL_W-1:0]    col_last;
    logic [ROW_W-1:0]    row_first;
    logic [ROW_W-1:0]    row_last;
    logic [GCOL_W-1:0]   glyph_col;
    logic [GROW_W-1:0]   glyph_row;
    logic [CODE_W-1:0]   char_code;
    logic [COLOR_W-1:0]  fore_color;
    logic [COLOR_W-1:0]  back_color;
    logic [CODE_W-1:0]   font_bits;
    logic                outside;
  } job_t;

endpackage

`default_nettype wire

[design/fbd_if.sv]
// Command and response channel interfaces of the frame buffer drawer.
`default_nettype none

interface fbd_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        opcode;
  logic signed [fbd_pkg::POS_W-1:0]  x_pos;
  logic signed [fbd_pkg::POS_W-1:0]  y_pos;
  logic [fbd_pkg::SIZE_W-1:0]        rect_width;
  logic [fbd_pkg::SIZE_W-1:0]        rect_height;
  logic [fbd_pkg::COLOR_W-1:0]       fore_color;
  logic [fbd_pkg::COLOR_W-1:0]       back_color;
  logic [fbd_pkg::CODE_W-1:0]        char_code;
  logic [fbd_pkg::GROW_W-1:0]        font_row;
  logic [fbd_pkg::CODE_W-1:0]        font_bits;

  modport source (
    output valid, opcode, x_pos, y_pos, rect_width, rect_height,
    output fore_color, back_color, char_code, font_row, font_bits,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_pos, y_pos, rect_width, rect_height,
    input  fore_color, back_color, char_code, font_row, font_bits,
    output ready
  );
endinterface

interface fbd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fbd_pkg::COLOR_W-1:0]  pixel_color;
  logic                         outside;

  modport source (output valid, pixel_color, outside, input ready);
  modport sink (input valid, pixel_color, outside, output ready);
endinterface

`default_nettype wire

[design/fbd_front.sv]
// Front end: configuration register, command decode and clipping into queue jobs.
`default_nettype none

module fbd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  fbd_cmd_if.sink                            cmd,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fbd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fbd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [fbd_pkg::PDATA_W-1:0]   prdata,
  input  wire logic                          q_ready,
  output logic                               q_push,
  output fbd_pkg::job_t                      q_job
);

  logic [fbd_pkg::COLOR_W-1:0] clear_color;

  logic signed [fbd_pkg::COORD_W-1:0] x_s, y_s, x_len, y_len, x_end, y_end;
  logic signed [fbd_pkg::COORD_W-1:0] col_lo, col_hi, row_lo, row_hi;
  logic signed [fbd_pkg::COORD_W-1:0] col_ofs, row_ofs, col_top, row_top;
  logic is_char, area_ok, off_panel, keep;

  // Clear color register, written by an APB access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_color <= '0;
    end else if (psel && penable && pwrite && paddr[2] == fbd_pkg::REG_CLEAR_COLOR) begin
      clear_color <= pwdata[fbd_pkg::COLOR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == fbd_pkg::REG_CLEAR_COLOR) ?
                  fbd_pkg::PDATA_W'(clear_color) : '0;

  // Clip the addressed window to the panel
  always_comb begin
    is_char = (cmd.opcode == fbd_pkg::OP_CHAR);
    x_s     = fbd_pkg::COORD_W'(cmd.x_pos);
    y_s     = fbd_pkg::COORD_W'(cmd.y_pos);
    x_len   = is_char ? fbd_pkg::GLYPH_W_S : $signed({3'b000, cmd.rect_width});
    y_len   = is_char ? fbd_pkg::GLYPH_H_S : $signed({3'b000, cmd.rect_height});
    x_end   = x_s + x_len;
    y_end   = y_s + y_len;
    col_lo  = (x_s < 0) ? '0 : x_s;
    row_lo  = (y_s < 0) ? '0 : y_s;
    col_hi  = (x_end > fbd_pkg::COLS_S) ? fbd_pkg::COLS_S : x_end;
    row_hi  = (y_end > fbd_pkg::ROWS_S) ? fbd_pkg::ROWS_S : y_end;
    col_top = col_hi - fbd_pkg::ONE_S;
    row_top = row_hi - fbd_pkg::ONE_S;
    col_ofs = col_lo - x_s;
    row_ofs = row_lo - y_s;
    area_ok = (col_lo < col_hi) && (row_lo < row_hi);
    off_panel = (x_s < 0) || (x_s >= fbd_pkg::COLS_S) ||
                (y_s < 0) || (y_s >= fbd_pkg::ROWS_S);
  end

  // Build the queue job for each opcode; empty windows and undefined opcodes are dropped
  always_comb begin
    q_job = '{
      kind:       fbd_pkg::K_FILL,
      col_first:  col_lo[fbd_pkg::COL_W-1:0],
      col_last:   col_top[fbd_pkg::COL_W-1:0],
      row_first:  row_lo[fbd_pkg::ROW_W-1:0],
      row_last:   row_top[fbd_pkg::ROW_W-1:0],
      glyph_col:  col_ofs[fbd_pkg::GCOL_W-1:0],
      glyph_row:  row_ofs[fbd_pkg::GROW_W-1:0],
      char_code:  cmd.char_code,
      fore_color: cmd.fore_color,
      back_color: cmd.back_color,
      font_bits:  cmd.font_bits,
      outside:    off_panel
    };
    keep = 1'b0;
    case (cmd.opcode)
      fbd_pkg::OP_CLEAR: begin
        keep             = 1'b1;
        q_job.col_first  = '0;
        q_job.col_last   = fbd_pkg::COL_W'(fbd_pkg::PANEL_COLS - 1);
        q_job.row_first  = '0;
        q_job.row_last   = fbd_pkg::ROW_W'(fbd_pkg::PANEL_ROWS - 1);
        q_job.fore_color = clear_color;
      end
      fbd_pkg::OP_RECT: begin
        keep = area_ok;
      end
      fbd_pkg::OP_CHAR: begin
        keep       = area_ok;
        q_job.kind = fbd_pkg::K_GLYPH;
      end
      fbd_pkg::OP_FONT: begin
        keep            = 1'b1;
        q_job.kind      = fbd_pkg::K_FONT;
        q_job.glyph_row = cmd.font_row;
      end
      fbd_pkg::OP_READ: begin
        keep            = 1'b1;
        q_job.kind      = fbd_pkg::K_READ;
        q_job.col_first = x_s[fbd_pkg::COL_W-1:0];
        q_job.row_first = y_s[fbd_pkg::ROW_W-1:0];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Every item is accepted once the queue has room
  assign cmd.ready = q_ready;
  assign q_push    = cmd.valid && q_ready && keep;

endmodule

`default_nettype wire

[design/fbd_queue.sv]
// Short job queue that decouples command decode from drawing.
`default_nettype none

module fbd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fbd_pkg::job_t  push_job,
  output logic                push_ready,
  output logic                pop_valid,
  input  wire logic           pop,
  output fbd_pkg::job_t       pop_job
);

  fbd_pkg::job_t slots [fbd_pkg::QUEUE_DEPTH];
  logic [fbd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [fbd_pkg::QCNT_W-1:0] count;

  assign push_ready = (count != fbd_pkg::QCNT_W'(fbd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/fbd_back.sv]
// Back end: frame and font memories, pixel sequencer and response register.
`default_nettype none

module fbd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire fbd_pkg::job_t  q_job,
  output logic                q_pop,
  fbd_rsp_if.source           rsp
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_FETCH  = 6'b000100,
    S_DRAW   = 6'b001000,
    S_RDREQ  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state, state_next;
  fbd_pkg::job_t cur;

  logic [fbd_pkg::COLOR_W-1:0] frame_mem [fbd_pkg::FRAME_DEPTH];
  logic [fbd_pkg::CODE_W-1:0]  font_mem  [fbd_pkg::FONT_DEPTH];
  logic [fbd_pkg::COLOR_W-1:0] frame_q;
  logic [fbd_pkg::CODE_W-1:0]  font_q;

  logic [fbd_pkg::COL_W-1:0]    col;
  logic [fbd_pkg::ROW_W-1:0]    row;
  logic [fbd_pkg::GCOL_W-1:0]   gcol;
  logic [fbd_pkg::GROW_W-1:0]   grow;
  logic [fbd_pkg::FRAME_AW-1:0] base, addr, setup_base, next_base;

  logic col_end, row_end, slot_free;
  logic frame_we, frame_re, font_we, font_re;
  logic [fbd_pkg::COLOR_W-1:0] pix_color;

  logic                        out_valid;
  logic [fbd_pkg::COLOR_W-1:0] out_color;
  logic                        out_outside;

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign col_end    = (col == cur.col_last);
  assign row_end    = (row == cur.row_last);
  assign slot_free  = !out_valid || rsp.ready;
  assign setup_base = fbd_pkg::FRAME_AW'(cur.row_first) * fbd_pkg::COL_STRIDE;
  assign next_base  = base + fbd_pkg::COL_STRIDE;

  assign frame_we  = (state == S_DRAW);
  assign frame_re  = (state == S_RDREQ);
  assign font_we   = (state == S_SETUP) && (cur.kind == fbd_pkg::K_FONT);
  assign font_re   = (state == S_FETCH);
  assign pix_color = (cur.kind == fbd_pkg::K_GLYPH && !font_q[gcol]) ?
                     cur.back_color : cur.fore_color;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        case (cur.kind)
          fbd_pkg::K_FILL:  state_next = S_DRAW;
          fbd_pkg::K_GLYPH: state_next = S_FETCH;
          fbd_pkg::K_READ:  state_next = cur.outside ? S_RESULT : S_RDREQ;
          default:          state_next = S_IDLE;
        endcase
      end
      S_FETCH: begin
        state_next = S_DRAW;
      end
      S_DRAW: begin
        if (col_end) begin
          if (row_end) begin
            state_next = S_IDLE;
          end else if (cur.kind == fbd_pkg::K_GLYPH) begin
            state_next = S_FETCH;
          end
        end
      end
      S_RDREQ: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Current job and pixel walk counters
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    case (state)
      S_SETUP: begin
        base <= setup_base;
        addr <= setup_base + fbd_pkg::FRAME_AW'(cur.col_first);
        col  <= cur.col_first;
        row  <= cur.row_first;
        gcol <= cur.glyph_col;
        grow <= cur.glyph_row;
      end
      S_DRAW: begin
        if (col_end) begin
          if (!row_end) begin
            base <= next_base;
            addr <= next_base + fbd_pkg::FRAME_AW'(cur.col_first);
            col  <= cur.col_first;
            row  <= row + 1'b1;
            gcol <= cur.glyph_col;
            grow <= grow + 1'b1;
          end
        end else begin
          addr <= addr + 1'b1;
          col  <= col + 1'b1;
          gcol <= gcol + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Frame store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[addr] <= pix_color;
    end
    if (frame_re) begin
      frame_q <= frame_mem[addr];
    end
  end

  // Font store: row loads and registered glyph row fetches
  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[{cur.char_code, cur.glyph_row}] <= cur.font_bits;
    end
    if (font_re) begin
      font_q <= font_mem[{cur.char_code, grow}];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && slot_free) begin
      out_color   <= cur.outside ? '0 : frame_q;
      out_outside <= cur.outside;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pixel_color = out_color;
  assign rsp.outside     = out_outside;

`ifndef SYNTHESIS
  // The walk never leaves the clipped window
  a_walk_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW) |-> (col <= cur.col_last && row <= cur.row_last))
    else $error("pixel walk left its clipped window");

  // The running address tracks the walk position
  a_addr_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW) |->
      (addr == fbd_pkg::FRAME_AW'(row) * fbd_pkg::COL_STRIDE + fbd_pkg::FRAME_AW'(col)))
    else $error("frame address out of step with row and column");

  // A response appears only from the result state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESULT))
    else $error("response raised outside the result state");
`endif

endmodule

`default_nettype wire

[design/framebuffer_text_and_rect_drawer_unit.sv]
// Top level of the frame buffer drawer: decode front, job queue and drawing back end.
// A fill runs setup, then draws each clipped pixel; clear fills the whole panel this way.
// A character runs setup, then per clipped row a font fetch and a draw of the clipped columns.
// A read runs setup, read request and result states; off the panel it skips the read request.
// A font load writes in setup; the back end draws one pixel per cycle on one frame store port.
// Synchronous reset clears control and clear_color; frame and font stores are not cleared.
`default_nettype none

module framebuffer_text_and_rect_drawer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  fbd_cmd_if.sink                            cmd,
  fbd_rsp_if.source                          rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fbd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fbd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [fbd_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  logic          q_push, q_ready, q_valid, q_pop;
  fbd_pkg::job_t push_job, pop_job;

  assign pready = 1'b1;

  fbd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  fbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (pop_job)
  );

  fbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

[tb/framebuffer_text_and_rect_drawer_unit_test.sv]
// Self-checking testbench of the frame buffer drawer: predicted frame store checked by pixel reads.
module framebuffer_text_and_rect_drawer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block does not define, used to check that they do nothing.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;
  localparam logic [fbd_pkg::PADDR_W-1:0] CLEAR_COLOR_ADDR = {fbd_pkg::REG_CLEAR_COLOR, 2'b00};
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 160;

  typedef struct {
    logic [2:0]                       opcode;
    logic signed [fbd_pkg::POS_W-1:0] x_pos;
    logic signed [fbd_pkg::POS_W-1:0] y_pos;
    logic [fbd_pkg::SIZE_W-1:0]       rect_width;
    logic [fbd_pkg::SIZE_W-1:0]       rect_height;
    logic [fbd_pkg::COLOR_W-1:0]      fore_color;
    logic [fbd_pkg::COLOR_W-1:0]      back_color;
    logic [fbd_pkg::CODE_W-1:0]       char_code;
    logic [fbd_pkg::GROW_W-1:0]       font_row;
    logic [fbd_pkg::CODE_W-1:0]       font_bits;
  } draw_cmd_t;

  typedef struct {
    logic [fbd_pkg::COLOR_W-1:0] pixel_color;
    logic                        outside;
    int                          x;
    int                          y;
  } pixel_read_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [fbd_pkg::PADDR_W-1:0] paddr;
  logic [fbd_pkg::PDATA_W-1:0] pwdata;
  logic [fbd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  fbd_cmd_if cmd_bus ();
  fbd_rsp_if rsp_bus ();

  framebuffer_text_and_rect_drawer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted contents of the block's stores and register.
  logic [fbd_pkg::COLOR_W-1:0] frame_image [fbd_pkg::FRAME_DEPTH];
  logic [fbd_pkg::CODE_W-1:0]  font_image [fbd_pkg::FONT_DEPTH];
  logic [fbd_pkg::COLOR_W-1:0] clear_color_image = '0;

  // Font rows loaded so far, so that only fully written glyphs are drawn.
  bit [fbd_pkg::GLYPH_H-1:0] glyph_rows_seen [fbd_pkg::GLYPH_COUNT];
  int loaded_glyphs[$];

  draw_cmd_t   pending_cmds[$];
  pixel_read_t expected_reads[$];
  draw_cmd_t   cmd_on_bus;

  int unsigned cmds_queued = 0;
  int unsigned cmd_offered = 0;
  int unsigned cmd_accepted = 0;
  int unsigned reads_checked = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int cmd_gap = 0;
  int rsp_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one accepted command to the predicted stores.
  function automatic void apply_command(input draw_cmd_t c);
    int x, y, w, h, xa, xb, ya, yb;
    logic [fbd_pkg::CODE_W-1:0] pattern;
    pixel_read_t r;
    x = int'(c.x_pos);
    y = int'(c.y_pos);
    w = int'(c.rect_width);
    h = int'(c.rect_height);
    case (c.opcode)
      fbd_pkg::OP_CLEAR: begin
        foreach (frame_image[i]) frame_image[i] = clear_color_image;
      end
      fbd_pkg::OP_RECT: begin
        xa = (x < 0) ? 0 : x;
        ya = (y < 0) ? 0 : y;
        xb = (x + w > fbd_pkg::PANEL_COLS) ? fbd_pkg::PANEL_COLS : x + w;
        yb = (y + h > fbd_pkg::PANEL_ROWS) ? fbd_pkg::PANEL_ROWS : y + h;
        for (int j = ya; j < yb; j++)
          for (int i = xa; i < xb; i++)
            frame_image[j * fbd_pkg::PANEL_COLS + i] = c.fore_color;
      end
      fbd_pkg::OP_CHAR: begin
        // A glyph with all of its columns off the panel is skipped as a whole.
        if (x < fbd_pkg::PANEL_COLS && x + fbd_pkg::GLYPH_W > 0) begin
          for (int j = 0; j < fbd_pkg::GLYPH_H; j++) begin
            pattern = font_image[int'(c.char_code) * fbd_pkg::GLYPH_H + j];
            for (int i = 0; i < fbd_pkg::GLYPH_W; i++) begin
              if (x + i >= 0 && x + i < fbd_pkg::PANEL_COLS &&
                  y + j >= 0 && y + j < fbd_pkg::PANEL_ROWS)
                frame_image[(y + j) * fbd_pkg::PANEL_COLS + x + i] =
                  pattern[i] ? c.fore_color : c.back_color;
            end
          end
        end
      end
      fbd_pkg::OP_FONT: begin
        font_image[int'(c.char_code) * fbd_pkg::GLYPH_H + int'(c.font_row)] = c.font_bits;
      end
      fbd_pkg::OP_READ: begin
        r.x = x;
        r.y = y;
        if (x < 0 || x >= fbd_pkg::PANEL_COLS || y < 0 || y >= fbd_pkg::PANEL_ROWS) begin
          r.pixel_color = '0;
          r.outside = 1'b1;
        end else begin
          r.pixel_color = frame_image[y * fbd_pkg::PANEL_COLS + x];
          r.outside = 1'b0;
        end
        expected_reads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Every field random; callers then set the ones the opcode uses.
  function automatic draw_cmd_t random_fields();
    draw_cmd_t c;
    c.opcode = 3'($urandom);
    c.x_pos = fbd_pkg::POS_W'($urandom);
    c.y_pos = fbd_pkg::POS_W'($urandom);
    c.rect_width = fbd_pkg::SIZE_W'($urandom);
    c.rect_height = fbd_pkg::SIZE_W'($urandom);
    c.fore_color = fbd_pkg::COLOR_W'($urandom);
    c.back_color = fbd_pkg::COLOR_W'($urandom);
    c.char_code = fbd_pkg::CODE_W'($urandom);
    c.font_row = fbd_pkg::GROW_W'($urandom);
    c.font_bits = fbd_pkg::CODE_W'($urandom);
    return c;
  endfunction

  function automatic void queue_cmd(input draw_cmd_t c);
    pending_cmds.push_back(c);
    cmds_queued++;
  endfunction

  function automatic void queue_plain(input logic [2:0] op);
    draw_cmd_t c;
    c = random_fields();
    c.opcode = op;
    queue_cmd(c);
  endfunction

  function automatic void queue_read(input int x, input int y);
    draw_cmd_t c;
    c = random_fields();
    c.opcode = fbd_pkg::OP_READ;
    c.x_pos = fbd_pkg::POS_W'(x);
    c.y_pos = fbd_pkg::POS_W'(y);
    queue_cmd(c);
  endfunction

  function automatic void queue_rect(input int x, input int y, input int w, input int h,
                                     input logic [fbd_pkg::COLOR_W-1:0] fg);
    draw_cmd_t c;
    c = random_fields();
    c.opcode = fbd_pkg::OP_RECT;
    c.x_pos = fbd_pkg::POS_W'(x);
    c.y_pos = fbd_pkg::POS_W'(y);
    c.rect_width = fbd_pkg::SIZE_W'(w);
    c.rect_height = fbd_pkg::SIZE_W'(h);
    c.fore_color = fg;
    queue_cmd(c);
  endfunction

  function automatic void queue_char(input int x, input int y, input int code,
                                     input logic [fbd_pkg::COLOR_W-1:0] fg,
                                     input logic [fbd_pkg::COLOR_W-1:0] bg);
    draw_cmd_t c;
    c = random_fields();
    c.opcode = fbd_pkg::OP_CHAR;
    c.x_pos = fbd_pkg::POS_W'(x);
    c.y_pos = fbd_pkg::POS_W'(y);
    c.char_code = fbd_pkg::CODE_W'(code);
    c.fore_color = fg;
    c.back_color = bg;
    queue_cmd(c);
  endfunction

  function automatic void queue_font_row(input int code, input int row,
                                         input logic [fbd_pkg::CODE_W-1:0] bits);
    draw_cmd_t c;
    c = random_fields();
    c.opcode = fbd_pkg::OP_FONT;
    c.char_code = fbd_pkg::CODE_W'(code);
    c.font_row = fbd_pkg::GROW_W'(row);
    c.font_bits = bits;
    if (glyph_rows_seen[code] != '1) begin
      glyph_rows_seen[code][row] = 1'b1;
      if (glyph_rows_seen[code] == '1) loaded_glyphs.push_back(code);
    end
    queue_cmd(c);
  endfunction

  // One random step: whole glyph loads, partial loads, text, rectangles, reads and noise.
  function automatic void random_step();
    int pick, code, rows, x, y, w, h;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      code = $urandom_range(0, fbd_pkg::GLYPH_COUNT - 1);
      for (int r = 0; r < fbd_pkg::GLYPH_H; r++)
        queue_font_row(code, r, fbd_pkg::CODE_W'($urandom));
    end else if (pick < 9) begin
      code = $urandom_range(0, fbd_pkg::GLYPH_COUNT - 1);
      rows = $urandom_range(1, fbd_pkg::GLYPH_H - 1);
      for (int k = 0; k < rows; k++)
        queue_font_row(code, $urandom_range(0, fbd_pkg::GLYPH_H - 1),
                       fbd_pkg::CODE_W'($urandom));
    end else if (pick < 40 && loaded_glyphs.size() > 0) begin
      code = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 4095) - 2048;
        y = $urandom_range(0, 4095) - 2048;
      end else begin
        x = $urandom_range(0, 264) - 12;
        y = $urandom_range(0, 280) - 20;
      end
      queue_char(x, y, code, fbd_pkg::COLOR_W'($urandom), fbd_pkg::COLOR_W'($urandom));
    end else if (pick < 62) begin
      // Large sizes are paired with a thin other side to keep the run short.
      case ($urandom_range(0, 3))
        0: begin
          w = $urandom_range(0, 2047);
          h = $urandom_range(0, 3);
          x = $urandom_range(0, 4095) - 2048;
          y = $urandom_range(0, 260) - 10;
        end
        1: begin
          w = $urandom_range(0, 3);
          h = $urandom_range(0, 2047);
          x = $urandom_range(0, 260) - 10;
          y = $urandom_range(0, 4095) - 2048;
        end
        default: begin
          w = $urandom_range(0, 24);
          h = $urandom_range(0, 24);
          x = $urandom_range(0, 280) - 30;
          y = $urandom_range(0, 280) - 30;
        end
      endcase
      queue_rect(x, y, w, h, fbd_pkg::COLOR_W'($urandom));
    end else if (pick < 97) begin
      if ($urandom_range(0, 6) == 0)
        queue_read($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
      else
        queue_read($urandom_range(0, fbd_pkg::PANEL_COLS - 1),
                   $urandom_range(0, fbd_pkg::PANEL_ROWS - 1));
    end else begin
      queue_plain(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
    end
  endfunction

  // Register write followed by a read back of the same register.
  task automatic write_clear_color(input logic [fbd_pkg::COLOR_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= CLEAR_COLOR_ADDR;
    pwdata <= fbd_pkg::PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    clear_color_image = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[fbd_pkg::COLOR_W-1:0] !== value) begin
      $display("%0t: clear_color read back expected %h, got %h", $time, value,
               prdata[fbd_pkg::COLOR_W-1:0]);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_until_drained();
    while (pending_cmds.size() != 0 || cmd_accepted != cmd_offered ||
           expected_reads.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Cycle limit and command transfers into the predictor.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("framebuffer_text_and_rect_drawer_unit_test failed");
      $finish;
    end else if (!rst && cmd_bus.valid && cmd_bus.ready) begin
      apply_command(cmd_on_bus);
      cmd_accepted++;
    end
  end

  // Command driver: the next pending command once the previous one is transferred.
  always @(negedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (cmd_accepted == cmd_offered) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_bus.valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        cmd_bus.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        cmd_gap = $urandom_range(0, 2);
        cmd_bus.valid <= 1'b0;
      end else begin
        cmd_on_bus = pending_cmds.pop_front();
        cmd_bus.opcode <= cmd_on_bus.opcode;
        cmd_bus.x_pos <= cmd_on_bus.x_pos;
        cmd_bus.y_pos <= cmd_on_bus.y_pos;
        cmd_bus.rect_width <= cmd_on_bus.rect_width;
        cmd_bus.rect_height <= cmd_on_bus.rect_height;
        cmd_bus.fore_color <= cmd_on_bus.fore_color;
        cmd_bus.back_color <= cmd_on_bus.back_color;
        cmd_bus.char_code <= cmd_on_bus.char_code;
        cmd_bus.font_row <= cmd_on_bus.font_row;
        cmd_bus.font_bits <= cmd_on_bus.font_bits;
        cmd_bus.valid <= 1'b1;
        cmd_offered++;
      end
    end
  end

  // Result receiver: short random stalls and one long hold-off that backs up the block.
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (!hold_done && reads_checked >= 30) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rsp_gap = $urandom_range(0, 2);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Result monitor: compare each pixel read with the oldest prediction.
  always @(posedge clk) begin
    pixel_read_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_reads.size() == 0) begin
        $display("%0t: unexpected result pixel_color %h outside %b", $time,
                 rsp_bus.pixel_color, rsp_bus.outside);
        error_count++;
      end else begin
        want = expected_reads.pop_front();
        reads_checked++;
        if (rsp_bus.pixel_color !== want.pixel_color) begin
          $display("%0t: read (%0d,%0d) pixel_color expected %h, got %h", $time, want.x,
                   want.y, want.pixel_color, rsp_bus.pixel_color);
          error_count++;
        end
        if (rsp_bus.outside !== want.outside) begin
          $display("%0t: read (%0d,%0d) outside expected %b, got %b", $time, want.x,
                   want.y, want.outside, rsp_bus.outside);
          error_count++;
        end
      end
    end
  end

  // Stimulus in phases, each started by a register write while the block is idle.
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.opcode = '0;
    cmd_bus.x_pos = '0;
    cmd_bus.y_pos = '0;
    cmd_bus.rect_width = '0;
    cmd_bus.rect_height = '0;
    cmd_bus.fore_color = '0;
    cmd_bus.back_color = '0;
    cmd_bus.char_code = '0;
    cmd_bus.font_row = '0;
    cmd_bus.font_bits = '0;
    rsp_bus.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on a white frame: panel corners, clipping and skipped glyphs.
    write_clear_color(16'hFFFF);
    queue_plain(fbd_pkg::OP_CLEAR);
    queue_read(0, 0);
    queue_read(fbd_pkg::PANEL_COLS - 1, fbd_pkg::PANEL_ROWS - 1);
    queue_read(-1, 0);
    queue_read(0, fbd_pkg::PANEL_ROWS);
    queue_read(-2048, 2047);
    queue_read(2047, -2048);
    queue_rect(-2048, -2048, 2047, 2047, 16'h1234);
    queue_rect(10, 10, 0, 5, 16'h0F0F);
    queue_rect(10, 10, 5, 0, 16'hF0F0);
    queue_rect(fbd_pkg::PANEL_COLS - 6, fbd_pkg::PANEL_ROWS - 6, 20, 20, 16'h0000);
    queue_rect(-3, -3, 6, 6, 16'hA5A5);
    for (int r = 0; r < fbd_pkg::GLYPH_H; r++)
      queue_font_row(fbd_pkg::GLYPH_COUNT - 1, r, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF :
                     (r == 2) ? 8'h01 : (r == 3) ? 8'h80 : fbd_pkg::CODE_W'($urandom));
    queue_font_row(0, 0, 8'h00);
    queue_char(-7, -15, fbd_pkg::GLYPH_COUNT - 1, 16'hFFFF, 16'h0000);
    queue_char(fbd_pkg::PANEL_COLS - 1, fbd_pkg::PANEL_ROWS - 8, fbd_pkg::GLYPH_COUNT - 1,
               16'h07E0, 16'hF800);
    queue_char(-8, 50, fbd_pkg::GLYPH_COUNT - 1, 16'h0001, 16'h0002);
    queue_char(fbd_pkg::PANEL_COLS, 50, fbd_pkg::GLYPH_COUNT - 1, 16'h0003, 16'h0004);
    queue_char(2047, -2048, fbd_pkg::GLYPH_COUNT - 1, 16'h0005, 16'h0006);
    queue_char(-2048, 2047, fbd_pkg::GLYPH_COUNT - 1, 16'h0007, 16'h0008);
    queue_char(100, 100, fbd_pkg::GLYPH_COUNT - 1, 16'h001F, 16'hFFE0);
    queue_read(0, 0);
    queue_read(fbd_pkg::PANEL_COLS - 1, fbd_pkg::PANEL_ROWS - 1);
    queue_read(fbd_pkg::PANEL_COLS - 1, fbd_pkg::PANEL_ROWS - 8);
    queue_read(100, 100);
    queue_read(107, 101);
    queue_read(3, 3);
    queue_read(2, 2);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) queue_plain(3'(op));
    queue_read(0, 0);
    wait_until_drained();

    // Random part on a black frame.
    write_clear_color(16'h0000);
    queue_plain(fbd_pkg::OP_CLEAR);
    while (cmds_queued < 450) random_step();
    queue_read(0, 0);
    wait_until_drained();

    // Random part on a random clear color; the last stretch runs without idling.
    write_clear_color(fbd_pkg::COLOR_W'($urandom));
    queue_plain(fbd_pkg::OP_CLEAR);
    while (cmds_queued < 700) random_step();
    while (pending_cmds.size() != 0) @(posedge clk);
    idle_on = 1'b0;
    while (cmds_queued < 850) random_step();
    queue_read(fbd_pkg::PANEL_COLS - 1, 0);
    wait_until_drained();

    if (error_count == 0) begin
      $display("framebuffer_text_and_rect_drawer_unit_test passed");
    end else begin
      $display("framebuffer_text_and_rect_drawer_unit_test failed");
    end
    $finish;
  end

endmodule
